[sv/sdes_pkg.sv]
`default_nettype none
package sdes_pkg;

	localparam int unsigned KeyW   = 10;
	localparam int unsigned BlkW   = 8;
	localparam int unsigned HalfW  = BlkW / 2;
	localparam int unsigned SubW   = 8;
	localparam int unsigned QDepth = 2;
	localparam int unsigned QAw    = $clog2(QDepth);

	typedef logic [KeyW-1:0]  key_t;
	typedef logic [BlkW-1:0]  blk_t;
	typedef logic [HalfW-1:0] half_t;
	typedef logic [SubW-1:0]  subkey_t;

	typedef struct packed {
		logic valid;
		blk_t data;
	} mid_word_t;

	localparam logic [1:0] SBOX0 [0:15] = '{
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3,
		2'd3, 2'd1, 2'd3, 2'd2
	};

	localparam logic [1:0] SBOX1 [0:15] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3
	};

	function automatic key_t p10(input key_t k);
		return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
	endfunction

	function automatic key_t rot_halves(input key_t k);
		return {k[8:5], k[9], k[3:0], k[4]};
	endfunction

	function automatic subkey_t p8(input key_t k);
		return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
	endfunction

	function automatic subkey_t subkey1(input key_t k);
		return p8(rot_halves(p10(k)));
	endfunction

	function automatic subkey_t subkey2(input key_t k);
		return p8(rot_halves(rot_halves(rot_halves(p10(k)))));
	endfunction

	function automatic blk_t ip(input blk_t b);
		return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
	endfunction

	function automatic blk_t ip_inv(input blk_t b);
		return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
	endfunction

	function automatic half_t round_f(input half_t r, input subkey_t k);
		subkey_t x;
		half_t   s;
		x = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ k;
		s = {SBOX0[{x[7], x[4], x[6:5]}], SBOX1[{x[3], x[0], x[2:1]}]};
		return {s[2], s[0], s[1], s[3]};
	endfunction

endpackage
`default_nettype wire

[sv/sdes_front.sv]
`default_nettype none
module sdes_front
	import sdes_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire blk_t      plaintext,
	input  wire subkey_t   k1,
	output mid_word_t      push_w,
	input  wire logic      push_ready
);

	logic  v_s1;
	blk_t  mid_s1;
	blk_t  b;
	half_t l1;

	assign b        = ip(plaintext);
	assign l1       = b[BlkW-1:HalfW] ^ round_f(b[HalfW-1:0], k1);
	assign in_ready = !v_s1 || push_ready;
	assign push_w   = '{valid: v_s1, data: mid_s1};

	// first round, halves swapped on the way out
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mid_s1 <= {b[HalfW-1:0], l1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

endmodule
`default_nettype wire

[sv/sdes_queue.sv]
`default_nettype none
module sdes_queue
	import sdes_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mid_word_t push_w,
	output logic           push_ready,
	output mid_word_t      pop_w,
	input  wire logic      pop_ready
);

	blk_t             mem_q [QDepth];
	logic [QAw-1:0]   wr_q;
	logic [QAw-1:0]   rd_q;
	logic [QAw:0]     cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != (QAw+1)'(QDepth));
	assign pop_w      = '{valid: (cnt_q != '0), data: mem_q[rd_q]};
	assign push       = push_w.valid && push_ready;
	assign pop        = pop_w.valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_w.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAw+1)'(QDepth))
		else $error("queue count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule
`default_nettype wire

[sv/sdes_back.sv]
`default_nettype none
module sdes_back
	import sdes_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mid_word_t pop_w,
	output logic           pop_ready,
	input  wire subkey_t   k2,
	output logic           out_valid,
	input  wire logic      out_ready,
	output blk_t           ciphertext
);

	logic  v_s2;
	blk_t  ct_s2;
	half_t l2;

	assign l2         = pop_w.data[BlkW-1:HalfW] ^ round_f(pop_w.data[HalfW-1:0], k2);
	assign pop_ready  = !v_s2 || out_ready;
	assign out_valid  = v_s2;
	assign ciphertext = ct_s2;

	always_ff @(posedge clk) begin
		if (pop_w.valid && pop_ready) begin
			ct_s2 <= ip_inv({l2, pop_w.data[HalfW-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pop_ready) begin
			v_s2 <= pop_w.valid;
		end
	end

endmodule
`default_nettype wire

[sv/sdes_encrypt_block.sv]
// channel  | handshake              | payload
// ---------+------------------------+------------------
// config   | cfg_we                 | cfg_wdata[9:0]
// input    | in_valid / in_ready    | plaintext[7:0]
// output   | out_valid / out_ready  | ciphertext[7:0]
//
// One word per cycle sustained while the output side is ready.
// Round one runs ahead of a two-word queue, round two and IP inverse behind it.
// Subkeys are derived when the key is written and held in registers.
// Reset clears the subkeys (key zero) and empties every stage.
// A stalled output fills the queue before input ready drops.
`default_nettype none
module sdes_encrypt_block
	import sdes_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire key_t cfg_wdata,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire blk_t plaintext,
	output logic      out_valid,
	input  wire logic out_ready,
	output blk_t      ciphertext
);

	subkey_t   k1_q;
	subkey_t   k2_q;
	mid_word_t push_w;
	mid_word_t pop_w;
	logic      push_ready;
	logic      pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
		end else if (cfg_we) begin
			k1_q <= subkey1(cfg_wdata);
			k2_q <= subkey2(cfg_wdata);
		end
	end

	sdes_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.plaintext  (plaintext),
		.k1         (k1_q),
		.push_w     (push_w),
		.push_ready (push_ready)
	);

	sdes_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_w     (push_w),
		.push_ready (push_ready),
		.pop_w      (pop_w),
		.pop_ready  (pop_ready)
	);

	sdes_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_w      (pop_w),
		.pop_ready  (pop_ready),
		.k2         (k2_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ciphertext (ciphertext)
	);

endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top
	import sdes_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STUCK_LIMIT = 5000;
	localparam int unsigned PHASE_WORDS = 100;
	localparam int unsigned NUM_PHASES  = 7;

	// permutation tables, 4 bits per entry, first entry in the top nibble
	localparam logic [39:0] P10_TAB = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
	localparam logic [39:0] P8_TAB  = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 8'h00};
	localparam logic [39:0] IP_TAB  = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7, 8'h00};
	localparam logic [39:0] EP_TAB  = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1, 8'h00};
	localparam logic [39:0] P4_TAB  = {4'd2, 4'd4, 4'd3, 4'd1, 24'h000000};
	localparam logic [39:0] IPI_TAB = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6, 8'h00};

	// S-boxes, row-major, 2 bits per entry, entry 0 in the top bits
	localparam logic [31:0] SB0_TAB = {
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3,
		2'd3, 2'd1, 2'd3, 2'd2
	};
	localparam logic [31:0] SB1_TAB = {
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3
	};

	typedef struct {
		logic set_key;
		key_t key;
		blk_t pt;
		logic known;
		blk_t ct;
	} vector_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic cfg_we    = 1'b0;
	key_t cfg_wdata = '0;
	logic in_valid  = 1'b0;
	logic in_ready;
	blk_t plaintext = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	blk_t ciphertext;

	key_t    active_key = '0;
	blk_t    pending_cipher [$];
	vector_t vectors [$];
	int      errors = 0;

	sdes_encrypt_block i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.plaintext  (plaintext),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ciphertext (ciphertext)
	);

	function automatic logic [9:0] permute_bits(logic [9:0] v, int w, logic [39:0] tab,
			int cnt);
		int n;
		int pos;
		logic [9:0] r;
		r = '0;
		for (n = 0; n < cnt; n++) begin
			pos = tab[39-4*n -: 4];
			r = {r[8:0], (pos >= 1 && pos <= w) ? v[w-pos] : 1'b0};
		end
		return r;
	endfunction

	function automatic logic [9:0] rotl_halves(logic [9:0] v);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = v[9:5];
		lo = v[4:0];
		return {hi[3:0], hi[4], lo[3:0], lo[4]};
	endfunction

	function automatic logic [1:0] sbox_pick(logic [31:0] box, logic [3:0] g);
		int idx;
		idx = {g[3], g[0]} * 4 + g[2:1];
		return box[31-2*idx -: 2];
	endfunction

	function automatic logic [3:0] feistel(logic [3:0] r, logic [7:0] sk);
		logic [9:0] t;
		logic [7:0] x;
		logic [3:0] s;
		t = permute_bits({6'b0, r}, 4, EP_TAB, 8);
		x = t[7:0] ^ sk;
		s = {sbox_pick(SB0_TAB, x[7:4]), sbox_pick(SB1_TAB, x[3:0])};
		t = permute_bits({6'b0, s}, 4, P4_TAB, 4);
		return t[3:0];
	endfunction

	function automatic blk_t sdes_cipher(key_t k, blk_t pt);
		logic [9:0] rk;
		logic [9:0] t;
		logic [7:0] k1;
		logic [7:0] k2;
		logic [3:0] l;
		logic [3:0] r;
		rk = rotl_halves(permute_bits(k, 10, P10_TAB, 10));
		t  = permute_bits(rk, 10, P8_TAB, 8);
		k1 = t[7:0];
		rk = rotl_halves(rotl_halves(rk));
		t  = permute_bits(rk, 10, P8_TAB, 8);
		k2 = t[7:0];
		t  = permute_bits({2'b0, pt}, 8, IP_TAB, 8);
		l  = t[7:4] ^ feistel(t[3:0], k1);
		r  = l;
		l  = t[3:0] ^ feistel(r, k2);
		t  = permute_bits({2'b0, l, r}, 8, IPI_TAB, 8);
		return t[7:0];
	endfunction

	task automatic add_vector(logic set_key, key_t key, blk_t pt, logic known, blk_t ct);
		vector_t v;
		v.set_key = set_key;
		v.key     = key;
		v.pt      = pt;
		v.known   = known;
		v.ct      = ct;
		vectors.push_back(v);
	endtask

	task automatic send_word(blk_t pt, logic known, blk_t ct);
		@(negedge clk);
		in_valid  <= 1'b1;
		plaintext <= pt;
		do
			@(posedge clk);
		while (!in_ready);
		pending_cipher.push_back(known ? ct : sdes_cipher(active_key, pt));
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_cipher.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_key(key_t k);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_we    <= 1'b0;
		active_key = k;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : sink_pattern
		int ready_run;
		int stall_run;
		logic nxt;
		ready_run = 0;
		stall_run = 0;
		forever begin
			@(negedge clk);
			if (ready_run == 0 && stall_run == 0) begin
				ready_run = $urandom_range(1, 24);
				stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			end
			if (stall_run > 0) begin
				nxt = 1'b0;
				stall_run--;
			end else begin
				nxt = 1'b1;
				ready_run--;
			end
			out_ready <= nxt;
		end
	end

	always @(posedge clk) begin
		blk_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cipher.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %02h", $time, ciphertext);
				errors++;
			end else begin
				want = pending_cipher.pop_front();
				if (ciphertext !== want) begin
					$display("%0t: ciphertext mismatch, expected %02h, got %02h",
						$time, want, ciphertext);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		@(posedge arst_n);
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: timeout, expected %0d words, got none", $time, pending_cipher.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int burst_left;
		int p;
		int i;
		key_t k;
		logic no_gaps;

		// reset key is zero
		add_vector(1'b0, '0, 8'h00, 1'b1, 8'hF0);
		add_vector(1'b0, '0, 8'hFF, 1'b0, '0);
		add_vector(1'b0, '0, 8'h01, 1'b0, '0);
		add_vector(1'b0, '0, 8'h80, 1'b0, '0);
		add_vector(1'b0, '0, 8'h55, 1'b0, '0);
		add_vector(1'b0, '0, 8'hAA, 1'b0, '0);
		add_vector(1'b1, 10'h3FF, 8'h00, 1'b0, '0);
		add_vector(1'b0, 10'h3FF, 8'hFF, 1'b0, '0);
		add_vector(1'b0, 10'h3FF, 8'h0F, 1'b0, '0);
		add_vector(1'b0, 10'h3FF, 8'hF0, 1'b0, '0);
		add_vector(1'b1, 10'h282, 8'h97, 1'b0, '0);
		add_vector(1'b0, 10'h282, 8'hBD, 1'b0, '0);
		add_vector(1'b0, 10'h282, 8'h00, 1'b0, '0);
		add_vector(1'b1, 10'h001, 8'h01, 1'b0, '0);
		add_vector(1'b0, 10'h001, 8'h80, 1'b0, '0);
		add_vector(1'b1, 10'h200, 8'h10, 1'b0, '0);
		add_vector(1'b0, 10'h200, 8'h08, 1'b0, '0);
		add_vector(1'b1, 10'h000, 8'h00, 1'b1, 8'hF0);
		add_vector(1'b0, 10'h000, 8'hFF, 1'b0, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (vectors[j]) begin
			if (vectors[j].set_key)
				load_key(vectors[j].key);
			send_word(vectors[j].pt, vectors[j].known, vectors[j].ct);
			hold_off($urandom_range(0, 2));
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			k = (p == 0) ? 10'h3FF : (p == 1) ? 10'h000 : 10'($urandom_range(0, 1023));
			load_key(k);
			no_gaps = (p == 2);
			burst_left = $urandom_range(1, 16);
			for (i = 0; i < PHASE_WORDS; i++) begin
				send_word(8'($urandom_range(0, 255)), 1'b0, '0);
				if (p == 3 && i == PHASE_WORDS / 2)
					drain();
				else if (!no_gaps) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 16);
						hold_off($urandom_range(1, 6));
					end else begin
						burst_left--;
					end
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
